FILE: hdl/vcht_pkg.sv
package vcht_pkg;

  // field widths fixed by the item format
  localparam int VERSION_W = 63;
  localparam int SUM_W     = 64;

  // default number of history slots
  localparam int HISTORY_DEPTH_DEF = 4;

  typedef logic [VERSION_W-1:0] version_t;
  typedef logic [SUM_W-1:0]     sum_t;

  // operation codes
  typedef enum logic [1:0] {
    KIND_UPDATE     = 2'd0,
    KIND_LOOKUP     = 2'd1,
    KIND_INVALIDATE = 2'd2,
    KIND_CLEAR      = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_CRC_MISMATCH = 2'd1,
    STATUS_NOT_FOUND    = 2'd2
  } status_t;

endpackage

FILE: hdl/version_checksum_history_table.sv
// Version checksum history table. An item (kind, version, crc_value,
// row_sum_value) is taken at a clock edge with start high and busy low; busy
// is low whenever rst is low, so an item may be issued in every cycle. Each
// item gives exactly one result via the input and result registers: done is
// high for one cycle with status, row_sum_warning and found_row_sum. The
// receiver cannot stall, so results must be captured in the cycle done is
// high. Every item is worked combinationally between the input register and
// the result register, comparing all HISTORY_DEPTH slots in parallel, and the
// slots are written at the same edge, so the next item already sees them.
module version_checksum_history_table #(
  parameter int HISTORY_DEPTH = vcht_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind,
  input  logic [vcht_pkg::VERSION_W-1:0] version,
  input  logic [vcht_pkg::SUM_W-1:0]    crc_value,
  input  logic [vcht_pkg::SUM_W-1:0]    row_sum_value,
  output logic                          done,
  output logic [1:0]                    status,
  output logic                          row_sum_warning,
  output logic [vcht_pkg::SUM_W-1:0]    found_row_sum
);

  localparam int N = HISTORY_DEPTH;

  // input register
  logic              valid_q;
  vcht_pkg::kind_t   kind_q;
  vcht_pkg::version_t ver_q;
  vcht_pkg::sum_t    crc_q;
  vcht_pkg::sum_t    row_q;

  // slot store
  vcht_pkg::version_t slot_version [N];
  vcht_pkg::sum_t     slot_crc     [N];
  vcht_pkg::sum_t     slot_row_sum [N];

  vcht_pkg::version_t slot_version_next [N];
  vcht_pkg::sum_t     slot_crc_next     [N];
  vcht_pkg::sum_t     slot_row_sum_next [N];

  // per-slot compare results
  logic [N-1:0] match;
  logic [N-1:0] ver_above;
  logic [N-1:0] is_min;
  logic [N-1:0] first_min;
  logic         any_match;
  logic         take_min_slot;

  vcht_pkg::status_t status_next;
  logic              warning_next;
  vcht_pkg::sum_t    found_next;

  assign busy = rst;

  // capture the item
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start;
    end
    kind_q <= vcht_pkg::kind_t'(kind);
    ver_q  <= version;
    crc_q  <= crc_value;
    row_q  <= row_sum_value;
  end

  // compare the item version against every slot, and each slot against the rest
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match[i]     = (slot_version[i] == ver_q);
      ver_above[i] = (ver_q > slot_version[i]);
      is_min[i]    = 1'b1;
      for (int j = 0; j < N; j++) begin
        if (slot_version[i] > slot_version[j]) begin
          is_min[i] = 1'b0;
        end
      end
    end
  end

  // lowest-numbered slot holding the smallest version
  assign first_min = is_min & (~is_min + {{(N-1){1'b0}}, 1'b1});

  assign any_match = |match;
  // newer than every slot, or unknown and newer than the oldest
  assign take_min_slot = !any_match && (|ver_above);

  // next slot contents and the result
  always_comb begin
    status_next  = vcht_pkg::STATUS_OK;
    warning_next = 1'b0;
    found_next   = '0;
    for (int i = 0; i < N; i++) begin
      slot_version_next[i] = slot_version[i];
      slot_crc_next[i]     = slot_crc[i];
      slot_row_sum_next[i] = slot_row_sum[i];
    end
    unique case (kind_q)
      vcht_pkg::KIND_UPDATE: begin
        for (int i = 0; i < N; i++) begin
          if (take_min_slot && first_min[i]) begin
            slot_version_next[i] = ver_q;
            slot_crc_next[i]     = crc_q;
            slot_row_sum_next[i] = row_q;
          end else if (match[i]) begin
            if (slot_crc[i] == '0) begin
              slot_crc_next[i]     = crc_q;
              slot_row_sum_next[i] = row_q;
            end else begin
              if (crc_q != '0 && crc_q != slot_crc[i]) begin
                status_next = vcht_pkg::STATUS_CRC_MISMATCH;
              end
              if (row_q != '0 && row_q != slot_row_sum[i]) begin
                warning_next = 1'b1;
              end
            end
          end
        end
      end
      vcht_pkg::KIND_LOOKUP: begin
        // later slots take precedence
        for (int i = 0; i < N; i++) begin
          if (match[i]) begin
            found_next = slot_row_sum[i];
          end
        end
        if (!any_match) begin
          status_next = vcht_pkg::STATUS_NOT_FOUND;
        end
      end
      vcht_pkg::KIND_INVALIDATE: begin
        for (int i = 0; i < N; i++) begin
          if (match[i]) begin
            slot_crc_next[i]     = '0;
            slot_row_sum_next[i] = '0;
          end
        end
      end
      vcht_pkg::KIND_CLEAR: begin
        for (int i = 0; i < N; i++) begin
          slot_version_next[i] = '0;
          slot_crc_next[i]     = '0;
          slot_row_sum_next[i] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // slot store update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        slot_version[i] <= '0;
        slot_crc[i]     <= '0;
        slot_row_sum[i] <= '0;
      end
    end else if (valid_q) begin
      for (int i = 0; i < N; i++) begin
        slot_version[i] <= slot_version_next[i];
        slot_crc[i]     <= slot_crc_next[i];
        slot_row_sum[i] <= slot_row_sum_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_q;
    end
    status          <= status_next;
    row_sum_warning <= warning_next;
    found_row_sum   <= found_next;
  end

endmodule

FILE: hdl/vcht_checker.sv
module vcht_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic [1:0]                     kind,
  input logic                           done,
  input logic [1:0]                     status,
  input logic                           row_sum_warning,
  input logic [vcht_pkg::SUM_W-1:0]     found_row_sum
);

  // every result belongs to an item taken earlier
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without an item");

  // an item always gives its result
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 (done || $past(rst)))
    else $error("item without a result");

  // a checksum mismatch or warning only comes from an update
  assert property (@(posedge clk) disable iff (rst)
    (done && (status == vcht_pkg::STATUS_CRC_MISMATCH || row_sum_warning))
      |-> $past(kind, 2) == vcht_pkg::KIND_UPDATE)
    else $error("update flags on another operation");

  // a returned row checksum or a miss only comes from a lookup, and not both
  assert property (@(posedge clk) disable iff (rst)
    (done && (status == vcht_pkg::STATUS_NOT_FOUND || found_row_sum != '0))
      |-> ($past(kind, 2) == vcht_pkg::KIND_LOOKUP
           && !(status == vcht_pkg::STATUS_NOT_FOUND && found_row_sum != '0)))
    else $error("lookup result on another operation");

endmodule

bind version_checksum_history_table vcht_checker u_vcht_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .kind            (kind),
  .done            (done),
  .status          (status),
  .row_sum_warning (row_sum_warning),
  .found_row_sum   (found_row_sum)
);
